// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the edge colorer RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("greedy_edge_colorer: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define GEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("greedy_edge_colorer: assertion failed");

`endif

// ===== rtl/core/gec_pkg.sv =====
// ---------------------------------------------------------------------------
// gec_pkg
// Types and constants of the greedy edge colorer.
// ---------------------------------------------------------------------------
package gec_pkg;

  localparam int VTX_W       = 12;
  localparam int NUM_VTX     = 1 << VTX_W;
  localparam int VCNT_W      = VTX_W + 1;
  localparam int NUM_COLORS  = 32;
  localparam int COLOR_W     = $clog2(NUM_COLORS);
  localparam int USED_W      = COLOR_W + 1;
  localparam int CNT_W       = 17;
  localparam int RANK_W      = 16;
  localparam int EPOCH_W     = 4;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 2 * VTX_W;
  localparam int OUT_FIELD_W = COLOR_W + RANK_W + USED_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

  localparam logic [VCNT_W-1:0] VTX_COUNT_RST = VCNT_W'(NUM_VTX);
  localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
  localparam logic [RANK_W-1:0] RANK_MAX      = '1;

  localparam logic ACT_EDGE     = 1'b0;
  localparam logic ACT_NEW_MESH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic [NUM_COLORS-1:0] mask_t;

  // One word of the vertex mask memory: mesh tag plus color mask
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    mask_t              mask;
  } mask_entry_t;

  typedef struct packed {
    logic             en;
    logic [VTX_W-1:0] addr;
    mask_entry_t      data;
  } mask_wr_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [RANK_W-1:0]  rank;
    logic [USED_W-1:0]  used;
    status_t            status;
  } res_t;

endpackage

// ===== rtl/core/gec_mask_ram.sv =====
// ---------------------------------------------------------------------------
// gec_mask_ram
// Per-vertex color mask store: two synchronous read ports, one write port.
// Read data is registered; a read at the written address returns old data.
// ---------------------------------------------------------------------------
module gec_mask_ram (
  input  logic                      clk,
  input  logic [gec_pkg::VTX_W-1:0] rd_a_addr,
  input  logic [gec_pkg::VTX_W-1:0] rd_b_addr,
  output gec_pkg::mask_entry_t      rd_a_data,
  output gec_pkg::mask_entry_t      rd_b_data,
  input  gec_pkg::mask_wr_t         wr
);
  import gec_pkg::*;

  mask_entry_t mem [NUM_VTX];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ===== rtl/core/gec_out_fifo.sv =====
// ---------------------------------------------------------------------------
// gec_out_fifo
// Two-entry result buffer between the color pipeline and the output stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gec_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gec_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output gec_pkg::res_t out_data
);
  import gec_pkg::*;

  res_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `GEC_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full)
  `GEC_ASSERT_NEXT(a_cnt_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 2'd1)
  `GEC_ASSERT_NEXT(a_cnt_down, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - 2'd1)

endmodule

// ===== rtl/core/gec_color_core.sv =====
// ---------------------------------------------------------------------------
// gec_color_core
// Read-modify-write pipeline over the vertex mask memory: picks the lowest
// free color, keeps per-color counters, mesh tag and the clearing sweep.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gec_color_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [gec_pkg::VCNT_W-1:0] vtx_limit,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [gec_pkg::VTX_W-1:0]  in_va,
  input  logic [gec_pkg::VTX_W-1:0]  in_vb,
  input  logic                       res_full,
  output logic                       res_push,
  output gec_pkg::res_t              res,
  output logic [gec_pkg::VTX_W-1:0]  rd_a_addr,
  output logic [gec_pkg::VTX_W-1:0]  rd_b_addr,
  input  gec_pkg::mask_entry_t       rd_a_data,
  input  gec_pkg::mask_entry_t       rd_b_data,
  output gec_pkg::mask_wr_t          wr
);
  import gec_pkg::*;

  // Clearing sweep (after reset and when the mesh tag wraps)
  logic               sweep_r;
  logic [VTX_W-1:0]   sweep_addr_r;
  logic [EPOCH_W-1:0] epoch_r;

  // Stage 1: mask data arrives, color is chosen
  logic             s1_valid_r;
  logic             s1_action_r;
  logic [VTX_W-1:0] s1_va_r;
  logic [VTX_W-1:0] s1_vb_r;

  // Stage 2: second mask write
  logic             s2_wr_r;
  logic [VTX_W-1:0] s2_addr_r;
  mask_t            s2_mask_r;

  // Last write, for a read issued on the same edge
  logic             fwd_valid_r;
  logic [VTX_W-1:0] fwd_addr_r;
  mask_t            fwd_mask_r;

  logic [CNT_W-1:0]  count_r [NUM_COLORS];
  logic [USED_W-1:0] open_r;

  logic               in_accept;
  mask_t              mask_a;
  mask_t              mask_b;
  mask_t              busy;
  mask_t              color_bit;
  logic [COLOR_W-1:0] pick;
  logic               found;
  logic               range_err;
  logic [USED_W-1:0]  pick_used;
  logic [CNT_W-1:0]   pick_cnt;
  logic               do_color;
  logic               wrap;

  assign in_ready  = !sweep_r && !s1_valid_r && !res_full;
  assign in_accept = in_valid && in_ready;
  assign rd_a_addr = in_va;
  assign rd_b_addr = in_vb;

  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_va_r)) begin
      mask_a = fwd_mask_r;
    end else if (rd_a_data.epoch == epoch_r) begin
      mask_a = rd_a_data.mask;
    end else begin
      mask_a = '0;
    end
    if (fwd_valid_r && (fwd_addr_r == s1_vb_r)) begin
      mask_b = fwd_mask_r;
    end else if (rd_b_data.epoch == epoch_r) begin
      mask_b = rd_b_data.mask;
    end else begin
      mask_b = '0;
    end
  end

  assign busy  = mask_a | mask_b;
  assign found = !(&busy);

  // Lowest clear bit of busy
  always_comb begin
    pick = '0;
    for (int i = NUM_COLORS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        pick = COLOR_W'(i);
      end
    end
  end

  assign color_bit = mask_t'(1) << pick;
  assign range_err = ({1'b0, s1_va_r} >= vtx_limit) || ({1'b0, s1_vb_r} >= vtx_limit);
  assign pick_cnt  = count_r[pick];
  assign pick_used = ({1'b0, pick} + USED_W'(1) > open_r) ?
                     ({1'b0, pick} + USED_W'(1)) : open_r;
  assign do_color  = s1_valid_r && (s1_action_r == ACT_EDGE) && !range_err && found;
  assign wrap      = (epoch_r == '1);

  always_comb begin
    res      = '0;
    res_push = s1_valid_r;
    if (s1_action_r == ACT_NEW_MESH) begin
      res.status = ST_OK;
    end else if (range_err) begin
      res.used   = open_r;
      res.status = ST_RANGE;
    end else if (!found) begin
      res.used   = open_r;
      res.status = ST_FULL;
    end else begin
      res.color  = pick;
      res.rank   = pick_cnt[CNT_W-1] ? RANK_MAX : pick_cnt[RANK_W-1:0];
      res.used   = pick_used;
      res.status = ST_OK;
    end
  end

  // Write port: sweep, first vertex in stage 1, second vertex in stage 2
  always_comb begin
    wr = '0;
    if (sweep_r) begin
      wr.en         = 1'b1;
      wr.addr       = sweep_addr_r;
      wr.data.epoch = epoch_r;
    end else if (do_color) begin
      wr.en         = 1'b1;
      wr.addr       = s1_va_r;
      wr.data.epoch = epoch_r;
      wr.data.mask  = mask_a | color_bit;
    end else if (s2_wr_r) begin
      wr.en         = 1'b1;
      wr.addr       = s2_addr_r;
      wr.data.epoch = epoch_r;
      wr.data.mask  = s2_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r      <= 1'b1;
      sweep_addr_r <= '0;
      epoch_r      <= '0;
      s1_valid_r   <= 1'b0;
      s2_wr_r      <= 1'b0;
      fwd_valid_r  <= 1'b0;
      open_r       <= '0;
      for (int i = 0; i < NUM_COLORS; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= in_accept;
      s2_wr_r     <= do_color;
      fwd_valid_r <= wr.en && !sweep_r;
      if (sweep_r) begin
        sweep_addr_r <= sweep_addr_r + VTX_W'(1);
        if (sweep_addr_r == '1) begin
          sweep_r <= 1'b0;
        end
      end
      if (s1_valid_r && (s1_action_r == ACT_NEW_MESH)) begin
        epoch_r <= epoch_r + EPOCH_W'(1);
        open_r  <= '0;
        for (int i = 0; i < NUM_COLORS; i++) begin
          count_r[i] <= '0;
        end
        if (wrap) begin
          sweep_r      <= 1'b1;
          sweep_addr_r <= '0;
        end
      end else if (do_color) begin
        open_r <= pick_used;
        if (pick_cnt != CNT_MAX) begin
          count_r[pick] <= pick_cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= in_action;
      s1_va_r     <= in_va;
      s1_vb_r     <= in_vb;
    end
    if (do_color) begin
      s2_addr_r <= s1_vb_r;
      s2_mask_r <= mask_b | color_bit;
    end
    fwd_addr_r <= wr.addr;
    fwd_mask_r <= wr.data.mask;
  end

  `GEC_ASSERT_NOW(a_no_accept_in_sweep, clk, rst_n, in_accept, !sweep_r)
  `GEC_ASSERT_NEXT(a_stage1_gap, clk, rst_n, s1_valid_r, !s1_valid_r)
  `GEC_ASSERT_NOW(a_s2_after_s1, clk, rst_n, s2_wr_r, $past(s1_valid_r) && !sweep_r)

endmodule

// ===== rtl/core/greedy_edge_colorer.sv =====
// An accepted item is registered in stage 1 of the core and then in the output buffer
//   before out_tvalid rises.
// No new item is accepted while one is in stage 1: the single write port of the mask
//   memory takes the two vertex mask updates of an edge on successive cycles.
// Reset: synchronous; afterward a clearing pass over every word of the mask memory holds
//   in_tready low. Every 16th new-mesh item repeats that pass as the mesh tag wraps.
// ---------------------------------------------------------------------------
// greedy_edge_colorer
// First-fit greedy edge coloring, one mesh edge or new-mesh marker per input transaction.
// ---------------------------------------------------------------------------
module greedy_edge_colorer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,   // vertex limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // first_vertex[11:0], second_vertex[23:12]
  input  logic        in_tuser,      // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // color[4:0], rank_in_color[20:5], colors_used[26:21]
  output logic [1:0]  out_tuser      // status
);
  import gec_pkg::*;

  logic [VCNT_W-1:0] vtx_limit_r;
  logic              res_full;
  logic              res_push;
  res_t              res;
  res_t              out_res;
  logic [VTX_W-1:0]  rd_a_addr;
  logic [VTX_W-1:0]  rd_b_addr;
  mask_entry_t       rd_a_data;
  mask_entry_t       rd_b_data;
  mask_wr_t          wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_limit_r <= VTX_COUNT_RST;
    end else if (cfg_wr_en) begin
      vtx_limit_r <= cfg_wr_data;
    end
  end

  gec_mask_ram u_mask_ram (
    .clk       (clk),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .wr        (wr)
  );

  gec_color_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .vtx_limit    (vtx_limit_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_action    (in_tuser),
    .in_va        (in_tdata[VTX_W-1:0]),
    .in_vb        (in_tdata[IN_DATA_W-1:VTX_W]),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res),
    .rd_a_addr    (rd_a_addr),
    .rd_b_addr    (rd_b_addr),
    .rd_a_data    (rd_a_data),
    .rd_b_data    (rd_b_data),
    .wr           (wr)
  );

  gec_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_res.used, out_res.rank, out_res.color};
  assign out_tuser = out_res.status;

endmodule
